// ===== hdl/utf8g_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8g_pkg
// Shared types, byte-class constants and the codepoint to glyph mapping for
// the UTF-8 glyph index decoder.
// ----------------------------------------------------------------------------
package utf8g_pkg;

	localparam logic [7:0] QMARK_CP    = 8'h3F;
	localparam logic [6:0] QMARK_GLYPH = 7'd31;

	localparam logic [7:0] MASK_CONT  = 8'hC0;
	localparam logic [7:0] CODE_CONT  = 8'h80;
	localparam logic [7:0] MASK_LEAD2 = 8'hE0;
	localparam logic [7:0] CODE_LEAD2 = 8'hC0;
	localparam logic [7:0] MASK_LEAD3 = 8'hF0;
	localparam logic [7:0] CODE_LEAD3 = 8'hE0;

	localparam logic [15:0] CP_A_RING  = 16'h00C5;
	localparam logic [15:0] CP_A_UML   = 16'h00C4;
	localparam logic [15:0] CP_O_UML   = 16'h00D6;
	localparam logic [15:0] CP_A_RING_L = 16'h00E5;
	localparam logic [15:0] CP_A_UML_L = 16'h00E4;
	localparam logic [15:0] CP_O_UML_L = 16'h00F6;

	localparam logic [15:0] CP_PRINT_LO = 16'd32;
	localparam logic [15:0] CP_PRINT_HI = 16'd126;

	// Results per input byte, at most three.
	localparam int MAX_RES = 3;

	typedef struct packed {
		logic [15:0] code_point;
		logic [6:0]  glyph_number;
	} result_t;

	// All results caused by one accepted byte.
	typedef struct packed {
		logic [1:0]               count;
		logic                     line_end;
		result_t [MAX_RES-1:0]    res;
	} batch_t;

	function automatic logic is_cont(input logic [7:0] b);
		return (b & MASK_CONT) == CODE_CONT;
	endfunction

	function automatic logic [6:0] glyph_of(input logic [15:0] cp);
		logic [15:0] off;
		off = cp - CP_PRINT_LO;
		if (cp >= CP_PRINT_LO && cp <= CP_PRINT_HI)
			return off[6:0];
		case (cp)
			CP_A_RING:   return 7'd95;
			CP_A_UML:    return 7'd96;
			CP_O_UML:    return 7'd97;
			CP_A_RING_L: return 7'd98;
			CP_A_UML_L:  return 7'd99;
			CP_O_UML_L:  return 7'd100;
			default:     return QMARK_GLYPH;
		endcase
	endfunction

	function automatic result_t make_result(input logic [15:0] cp);
		result_t r;
		r.code_point   = cp;
		r.glyph_number = glyph_of(cp);
		return r;
	endfunction

endpackage

// ===== hdl/utf8g_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8g_decode
// Holds the pending bytes of an unfinished sequence and, for each byte
// offered, works out every result it causes and the pending state after it.
// ----------------------------------------------------------------------------
module utf8g_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          text_byte,
	input  logic                line_end,
	input  logic                accept,
	output utf8g_pkg::batch_t   batch
);
	import utf8g_pkg::*;

	logic [7:0] pend_q [2];
	logic [1:0] pend_cnt_q;

	logic [7:0] q [5];
	logic [1:0] len;
	logic [1:0] pos;
	logic [1:0] avail;
	logic [1:0] n;
	logic       stop;
	logic [7:0] h;
	logic [7:0] b1;
	logic [7:0] b2;
	logic [2:0] ix;
	logic [7:0] pend_d [2];
	logic [1:0] pend_cnt_d;

	always_comb begin
		q[0] = 8'h00;
		q[1] = 8'h00;
		q[2] = 8'h00;
		q[3] = 8'h00;
		q[4] = 8'h00;
		case (pend_cnt_q)
			2'd0: begin
				q[0] = text_byte;
			end
			2'd1: begin
				q[0] = pend_q[0];
				q[1] = text_byte;
			end
			default: begin
				q[0] = pend_q[0];
				q[1] = pend_q[1];
				q[2] = text_byte;
			end
		endcase
		len = (pend_cnt_q > 2'd2) ? 2'd3 : pend_cnt_q + 2'd1;

		pos   = 2'd0;
		n     = 2'd0;
		stop  = 1'b0;
		avail = 2'd0;
		h     = 8'h00;
		b1    = 8'h00;
		b2    = 8'h00;
		ix    = 3'd0;
		batch.res = '0;
		batch.line_end = line_end;

		// At most three bytes, so at most three decode steps.
		for (int i = 0; i < MAX_RES; i++) begin
			if (!stop && pos < len) begin
				ix    = {1'b0, pos};
				h     = q[ix];
				b1    = q[ix + 3'd1];
				b2    = q[ix + 3'd2];
				avail = len - pos;
				if (!h[7]) begin
					batch.res[n] = make_result({8'h00, h});
					n   = n + 2'd1;
					pos = pos + 2'd1;
				end else if ((h & MASK_LEAD2) == CODE_LEAD2) begin
					if (avail < 2'd2) begin
						if (!line_end) begin
							stop = 1'b1;
						end else begin
							batch.res[n] = make_result({8'h00, QMARK_CP});
							n   = n + 2'd1;
							pos = pos + 2'd1;
						end
					end else if (is_cont(b1)) begin
						batch.res[n] = make_result({5'd0, h[4:0], b1[5:0]});
						n   = n + 2'd1;
						pos = pos + 2'd2;
					end else begin
						batch.res[n] = make_result({8'h00, QMARK_CP});
						n   = n + 2'd1;
						pos = pos + 2'd1;
					end
				end else if ((h & MASK_LEAD3) == CODE_LEAD3) begin
					if (avail >= 2'd2 && !is_cont(b1)) begin
						// fail early on a bad first continuation
						batch.res[n] = make_result({8'h00, QMARK_CP});
						n   = n + 2'd1;
						pos = pos + 2'd1;
					end else if (avail < 2'd3) begin
						if (!line_end) begin
							stop = 1'b1;
						end else begin
							batch.res[n] = make_result({8'h00, QMARK_CP});
							n   = n + 2'd1;
							pos = pos + 2'd1;
						end
					end else if (is_cont(b2)) begin
						batch.res[n] = make_result({h[3:0], b1[5:0], b2[5:0]});
						n   = n + 2'd1;
						pos = pos + 2'd3;
					end else begin
						batch.res[n] = make_result({8'h00, QMARK_CP});
						n   = n + 2'd1;
						pos = pos + 2'd1;
					end
				end else begin
					// stray continuation or four-byte lead
					batch.res[n] = make_result({8'h00, QMARK_CP});
					n   = n + 2'd1;
					pos = pos + 2'd1;
				end
			end
		end

		batch.count = n;
		ix          = {1'b0, pos};
		pend_cnt_d  = len - pos;
		pend_d[0]   = q[ix];
		pend_d[1]   = q[ix + 3'd1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q[0]  <= 8'h00;
			pend_q[1]  <= 8'h00;
			pend_cnt_q <= 2'd0;
		end else if (accept) begin
			pend_q[0]  <= pend_d[0];
			pend_q[1]  <= pend_d[1];
			pend_cnt_q <= pend_cnt_d;
		end
	end

endmodule

// ===== hdl/utf8g_outbuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8g_outbuf
// Result register for up to three results of one byte; hands them out one
// beat at a time and takes the next batch when empty or as the last one leaves.
// ----------------------------------------------------------------------------
module utf8g_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  utf8g_pkg::batch_t   batch,
	input  logic                load_req,
	output logic                can_load,
	output logic                m_tvalid,
	input  logic                m_tready,
	output utf8g_pkg::result_t  head,
	output logic                run_last,
	output logic                line_done
);
	import utf8g_pkg::*;

	result_t [MAX_RES-1:0] res_q;
	logic [1:0]            cnt_q;
	logic                  end_q;
	logic                  pop;

	assign m_tvalid  = cnt_q != 2'd0;
	assign pop       = m_tvalid && m_tready;
	assign can_load  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);
	assign head      = res_q[0];
	assign run_last  = cnt_q == 2'd1;
	assign line_done = (cnt_q == 2'd1) && end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load_req && can_load) begin
			cnt_q <= batch.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_req && can_load) begin
			res_q <= batch.res;
			end_q <= batch.line_end;
		end else if (pop) begin
			// advance the next result to the head
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

// ===== hdl/utf8_to_glyph_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_glyph_index
// Streaming UTF-8 decoder (one to three byte forms) that maps each codepoint
// to a glyph atlas index.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                tlast      tuser
//  s_*       in   [7:0] text_byte                      line_end   -
//  m_*       out  [15:0] code_point, [22:16] glyph     run_last   line_done
//
//  A byte is decoded in the cycle it is taken; its results sit in the result
//  register from the next cycle on and leave one beat per cycle while m_tready
//  is high. One byte per cycle while m_tready is high and each byte gives at
//  most one result; a byte with more holds the input until its last result leaves.
//  A stall on m_tready holds the result register and closes s_tready.
//  Reset clears the pending bytes and empties the result register.
// ----------------------------------------------------------------------------
module utf8_to_glyph_index (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] code_point, [22:16] glyph_number, [23] zero
	output logic        m_tlast,
	output logic        m_tuser    // [0] line_done
);
	import utf8g_pkg::*;

	batch_t  batch;
	result_t head;
	logic    can_load;
	logic    accept;

	assign s_tready = can_load;
	assign accept   = s_tvalid && can_load;

	utf8g_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_byte (s_tdata),
		.line_end  (s_tlast),
		.accept    (accept),
		.batch     (batch)
	);

	utf8g_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.batch     (batch),
		.load_req  (accept),
		.can_load  (can_load),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.head      (head),
		.run_last  (m_tlast),
		.line_done (m_tuser)
	);

	assign m_tdata = {1'b0, head.glyph_number, head.code_point};

endmodule

// ===== dv/glyph_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_result_checker
// Watches both stream channels of utf8_to_glyph_index. It decodes every
// accepted text byte with its own UTF-8 decoder and glyph map, and queues the
// results that the byte should cause. It then compares each result beat with
// the oldest queued result, field by field.
// ----------------------------------------------------------------------------
module glyph_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [15:0] code_point, [22:16] glyph_number, [23] zero
	input  logic        m_tlast,
	input  logic        m_tuser,   // [0] line_done
	output int          fail_count,
	output int          open_results
);
	import utf8g_pkg::*;

	typedef struct {
		logic [15:0] code_point;
		logic [6:0]  glyph_number;
		logic        run_last;
		logic        line_done;
	} glyph_beat_t;

	localparam logic [15:0] BAD_CP = {8'h00, QMARK_CP};

	glyph_beat_t pending_glyphs [$];
	logic [7:0]  held_bytes [2];
	int          held_count = 0;
	int          errors = 0;

	function automatic logic is_tail_byte(input logic [7:0] b);
		return (b & MASK_CONT) == CODE_CONT;
	endfunction

	function automatic logic [6:0] atlas_index(input logic [15:0] cp);
		logic [15:0] rel;
		rel = cp - CP_PRINT_LO;
		if (cp >= CP_PRINT_LO && cp <= CP_PRINT_HI)
			return rel[6:0];
		case (cp)
			CP_A_RING:   return 7'd95;
			CP_A_UML:    return 7'd96;
			CP_O_UML:    return 7'd97;
			CP_A_RING_L: return 7'd98;
			CP_A_UML_L:  return 7'd99;
			CP_O_UML_L:  return 7'd100;
			default:     return QMARK_GLYPH;
		endcase
	endfunction

	task automatic push_glyph(input logic [15:0] cp);
		glyph_beat_t g;
		g.code_point   = cp;
		g.glyph_number = atlas_index(cp);
		g.run_last     = 1'b0;
		g.line_done    = 1'b0;
		pending_glyphs.insert(pending_glyphs.size(), g);
	endtask

	// Decode the held bytes plus the new one; keep any unfinished tail.
	task automatic decode_byte(input logic [7:0] b, input logic lend);
		logic [7:0] q [3];
		logic [7:0] h;
		int len, pos, avail, first, i;
		logic stop;
		q[0] = held_bytes[0];
		q[1] = held_bytes[1];
		q[2] = 8'h00;
		q[2'(held_count)] = b;
		len   = held_count + 1;
		pos   = 0;
		stop  = 1'b0;
		first = pending_glyphs.size();
		while (pos < len && !stop) begin
			h     = q[2'(pos)];
			avail = len - pos;
			if (h < 8'h80) begin
				push_glyph({8'h00, h});
				pos += 1;
			end else if ((h & MASK_LEAD2) == CODE_LEAD2) begin
				if (avail < 2) begin
					if (!lend) begin
						stop = 1'b1;
					end else begin
						push_glyph(BAD_CP);
						pos += 1;
					end
				end else if (is_tail_byte(q[2'(pos+1)])) begin
					push_glyph({5'd0, h[4:0], q[2'(pos+1)][5:0]});
					pos += 2;
				end else begin
					push_glyph(BAD_CP);
					pos += 1;
				end
			end else if ((h & MASK_LEAD3) == CODE_LEAD3) begin
				// a bad first continuation fails at once
				if (avail >= 2 && !is_tail_byte(q[2'(pos+1)])) begin
					push_glyph(BAD_CP);
					pos += 1;
				end else if (avail < 3) begin
					if (!lend) begin
						stop = 1'b1;
					end else begin
						push_glyph(BAD_CP);
						pos += 1;
					end
				end else if (is_tail_byte(q[2'(pos+2)])) begin
					push_glyph({h[3:0], q[2'(pos+1)][5:0], q[2'(pos+2)][5:0]});
					pos += 3;
				end else begin
					push_glyph(BAD_CP);
					pos += 1;
				end
			end else begin
				push_glyph(BAD_CP);
				pos += 1;
			end
		end
		held_count = (len - pos > 2) ? 2 : len - pos;
		for (i = 0; i < held_count; i++)
			held_bytes[1'(i)] = q[2'(pos+i)];
		if (pending_glyphs.size() > first) begin
			pending_glyphs[pending_glyphs.size()-1].run_last  = 1'b1;
			pending_glyphs[pending_glyphs.size()-1].line_done = lend;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		glyph_beat_t want;
		if (!arst_n) begin
			pending_glyphs.delete();
			held_bytes[0] = 8'h00;
			held_bytes[1] = 8'h00;
			held_count    = 0;
			open_results <= 0;
		end else begin
			// compare first: a result never comes from the byte taken on this edge
			if (m_tvalid && m_tready) begin
				if (pending_glyphs.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat exp none / act cp=%h glyph=%0d last=%b done=%b",
						$time, m_tdata[15:0], m_tdata[22:16], m_tlast, m_tuser);
				end else begin
					want = pending_glyphs.pop_front();
					if (m_tdata[15:0] !== want.code_point ||
						m_tdata[22:16] !== want.glyph_number ||
						m_tdata[23] !== 1'b0 || m_tlast !== want.run_last ||
						m_tuser !== want.line_done) begin
						errors++;
						$display({"%0t: mismatch exp cp=%h glyph=%0d last=%b done=%b pad=0",
							" / act cp=%h glyph=%0d last=%b done=%b pad=%b"},
							$time, want.code_point, want.glyph_number, want.run_last,
							want.line_done, m_tdata[15:0], m_tdata[22:16], m_tlast,
							m_tuser, m_tdata[23]);
					end
				end
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			open_results <= pending_glyphs.size();
		end
		fail_count <= errors;
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the utf8_to_glyph_index bench. It drives directed byte lines that
// cover each decoder corner, then random lines of mostly well-formed UTF-8
// mixed with broken and stray bytes. Three idling phases run on the two
// channels. The checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;

	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_BYTES = 50;   // per idling phase
	localparam int TAIL_CYCLES  = 16;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] text_byte
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [15:0] code_point, [22:16] glyph_number, [23] zero
	logic        m_tlast;
	logic        m_tuser;   // [0] line_done

	int fail_count;
	int open_results;
	int tx_idle = 13;
	int rx_idle = 62;
	int quiet_cycles = 0;

	utf8_to_glyph_index u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	glyph_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.open_results (open_results)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle);
	end

	// end the run if neither channel moves a beat for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL utf8_to_glyph_index");
				$finish;
			end
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// hold off the sender until every queued result has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (open_results != 0)
			@(posedge clk);
	endtask

	task automatic send_random_line(output int sent);
		logic [7:0] seq [$];
		logic [7:0] rb;
		int nseg, kind, i;
		nseg = $urandom_range(1, 6);
		repeat (nseg) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				rb = 8'($urandom_range(32, 126));
				seq.insert(seq.size(), rb);
			end else if (kind < 35) begin
				rb = 8'($urandom_range(0, 127));
				seq.insert(seq.size(), rb);
			end else if (kind < 50) begin
				seq.insert(seq.size(), 8'hC3);
				case ($urandom_range(0, 5))
					0:       seq.insert(seq.size(), 8'h85);
					1:       seq.insert(seq.size(), 8'h84);
					2:       seq.insert(seq.size(), 8'h96);
					3:       seq.insert(seq.size(), 8'hA5);
					4:       seq.insert(seq.size(), 8'hA4);
					default: seq.insert(seq.size(), 8'hB6);
				endcase
			end else if (kind < 62) begin
				rb = 8'($urandom_range(8'hC0, 8'hDF));
				seq.insert(seq.size(), rb);
				rb = 8'($urandom_range(8'h80, 8'hBF));
				seq.insert(seq.size(), rb);
			end else if (kind < 75) begin
				rb = 8'($urandom_range(8'hE0, 8'hEF));
				seq.insert(seq.size(), rb);
				repeat (2) begin
					rb = 8'($urandom_range(8'h80, 8'hBF));
					seq.insert(seq.size(), rb);
				end
			end else if (kind < 80) begin
				rb = 8'($urandom_range(8'h80, 8'hBF));
				seq.insert(seq.size(), rb);
			end else if (kind < 84) begin
				rb = 8'($urandom_range(8'hF0, 8'hFF));
				seq.insert(seq.size(), rb);
			end else if (kind < 89) begin
				rb = 8'($urandom_range(8'hC0, 8'hDF));
				seq.insert(seq.size(), rb);
			end else if (kind < 94) begin
				// three-byte lead missing its last continuation
				rb = 8'($urandom_range(8'hE0, 8'hEF));
				seq.insert(seq.size(), rb);
				rb = 8'($urandom_range(8'h80, 8'hBF));
				seq.insert(seq.size(), rb);
			end else begin
				rb = 8'($urandom_range(0, 255));
				seq.insert(seq.size(), rb);
			end
		end
		for (i = 0; i < seq.size(); i++)
			send_beat(seq[i], (i == seq.size() - 1) || ($urandom_range(0, 49) == 0));
		sent = seq.size();
	endtask

	task automatic run_phase(input int tx, input int rx);
		int done_bytes, n;
		tx_idle    = tx;
		rx_idle    = rx;
		done_bytes = 0;
		while (done_bytes < RANDOM_BYTES) begin
			send_random_line(n);
			done_bytes += n;
		end
		drain();
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tlast  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// printable range edges and control bytes
		send_beat(8'h00, 1'b0);
		send_beat(8'h7F, 1'b0);
		send_beat(8'h20, 1'b0);
		send_beat(8'h7E, 1'b1);
		// two- and three-byte forms, outside and at the codepoint top
		send_beat(8'hC3, 1'b0);
		send_beat(8'h85, 1'b0);
		send_beat(8'hE2, 1'b0);
		send_beat(8'h82, 1'b0);
		send_beat(8'hAC, 1'b0);
		send_beat(8'hEF, 1'b0);
		send_beat(8'hBF, 1'b0);
		send_beat(8'hBF, 1'b1);
		// stray continuation and four-byte leads
		send_beat(8'h80, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'hF0, 1'b0);
		// broken two-byte form, then early failure of a three-byte lead
		send_beat(8'hC3, 1'b0);
		send_beat(8'h41, 1'b0);
		send_beat(8'hE2, 1'b0);
		send_beat(8'h41, 1'b0);
		// third byte breaks the form: three beats from one byte
		send_beat(8'hE2, 1'b0);
		send_beat(8'h82, 1'b0);
		send_beat(8'h41, 1'b0);
		// leads cut off by the line end
		send_beat(8'hC3, 1'b1);
		send_beat(8'hE2, 1'b0);
		send_beat(8'h82, 1'b1);
		drain();

		run_phase(13, 62);
		run_phase(62, 13);
		run_phase(0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && open_results == 0)
			$display("PASS utf8_to_glyph_index");
		else
			$display("FAIL utf8_to_glyph_index");
		$finish;
	end

endmodule
